>>> rtl/named_slot_table_core_macros.svh
// Assertion macros for the named slot table checker.
// Used by nst_checker.sv; expects clk and rst in scope at the point of use.
`ifndef NAMED_SLOT_TABLE_CORE_MACROS_SVH
`define NAMED_SLOT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define NST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nst_pkg.sv
// Shared types, widths, request and status codes for the named slot table.
// No dependencies; imported by every other file of the block but the macro header.
`timescale 1ns / 1ps

package nst_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int NAME_BYTES  = 32;
  localparam int NAME_W      = NAME_BYTES * 8;
  localparam int WORD_W      = 64;
  localparam int ID_W        = 32;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int OUT_SLOT_W  = 6;
  localparam int OUT_COUNT_W = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LONG    = 3'd4;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;    // request accepted: capture key and clear scan results
    logic issue;   // read slot at scan address
    logic commit;  // apply the update and load the result register
  } nst_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic cmp_busy;  // a compare is still in flight
  } nst_stat_t;

  // Zero every byte from the first zero byte on (name is a C string).
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] key;
    logic              ended;
    key   = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      ended = ended | (raw[8*b +: 8] == 8'h00);
      key[8*b +: 8] = ended ? 8'h00 : raw[8*b +: 8];
    end
    return key;
  endfunction

endpackage

>>> rtl/nst_if.sv
// Request and response channel interfaces for the named slot table.
// Depends on nst_pkg for field widths.
`timescale 1ns / 1ps

interface nst_req_if
  import nst_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] name_word0;
  logic [WORD_W-1:0] name_word1;
  logic [WORD_W-1:0] name_word2;
  logic [WORD_W-1:0] name_word3;
  logic [ID_W-1:0]   entry_id;

  modport source (output valid, req_type, name_word0, name_word1, name_word2,
                  name_word3, entry_id, input ready);
  modport sink (input valid, req_type, name_word0, name_word1, name_word2,
                name_word3, entry_id, output ready);
endinterface

interface nst_rsp_if
  import nst_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [OUT_SLOT_W-1:0]  slot_index;
  logic [ID_W-1:0]        found_id;
  logic [OUT_COUNT_W-1:0] entry_count;

  modport source (output valid, status, slot_index, found_id, entry_count,
                  input ready);
  modport sink (input valid, status, slot_index, found_id, entry_count,
                output ready);
endinterface

>>> rtl/nst_ctrl.sv
// Sequencer for the named slot table: accept, slot scan, drain, commit.
// Depends on nst_pkg; drives nst_datapath through nst_cmd_t.
`timescale 1ns / 1ps

module nst_ctrl
  import nst_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output nst_cmd_t          cmd,
  input  nst_stat_t         stat,
  output logic [SLOT_W-1:0] scan_addr
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.issue  = (state == S_SCAN);
    cmd.commit = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_addr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // new response on commit, otherwise drop once taken
      if (state == S_DONE && out_free) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          scan_addr <= '0;
          if (req_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_addr == LAST_SLOT) state <= S_DRAIN;
          else scan_addr <= scan_addr + 1'b1;
        end
        S_DRAIN: begin
          if (!stat.cmp_busy) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/nst_datapath.sv
// Datapath: name/id memories, valid bits, entry count, compare stage,
// update decision and result register. Depends on nst_pkg.
`timescale 1ns / 1ps

module nst_datapath
  import nst_pkg::*;
#(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int COUNT_W = $clog2(SLOTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nst_cmd_t               cmd,
  output nst_stat_t              stat,
  input  logic [SLOT_W-1:0]      scan_addr,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [NAME_W-1:0]      in_name,
  input  logic [ID_W-1:0]        in_entry_id,
  output logic [STATUS_W-1:0]    status,
  output logic [OUT_SLOT_W-1:0]  slot_index,
  output logic [ID_W-1:0]        found_id,
  output logic [OUT_COUNT_W-1:0] entry_count
);

  logic [NAME_W-1:0] name_mem [SLOTS];
  logic [ID_W-1:0]   id_mem   [SLOTS];
  logic [SLOTS-1:0]  valid_bits;
  logic [COUNT_W-1:0] live_count;

  // captured request
  logic [NAME_W-1:0] key;
  logic [REQ_W-1:0]  req_q;
  logic [ID_W-1:0]   id_q;
  logic              too_long;

  // compare stage
  logic              cmp_vld;
  logic [SLOT_W-1:0] cmp_addr;
  logic              cmp_bit;
  logic [NAME_W-1:0] rd_name;
  logic [ID_W-1:0]   rd_id;
  logic              hit;

  // scan results
  logic              match_found;
  logic [SLOT_W-1:0] match_slot;
  logic [ID_W-1:0]   match_id;
  logic              free_found;
  logic [SLOT_W-1:0] open_slot;

  // commit decision
  logic [STATUS_W-1:0] st_next;
  logic [SLOT_W-1:0]   slot_next;
  logic [ID_W-1:0]     id_next;
  logic [COUNT_W-1:0]  count_next;
  logic                wr_en;
  logic                set_bit;
  logic                clr_bit;

  assign stat.cmp_busy = cmp_vld;
  assign hit = cmp_vld && cmp_bit && (rd_name == key);

  always_comb begin
    st_next    = ST_MISSING;
    slot_next  = '0;
    id_next    = '0;
    count_next = live_count;
    wr_en      = 1'b0;
    set_bit    = 1'b0;
    clr_bit    = 1'b0;
    unique case (req_q)
      REQ_ADD: begin
        if (too_long) begin
          st_next = ST_LONG;
        end else if (match_found) begin
          st_next = ST_DUP;
        end else if (!free_found) begin
          st_next = ST_FULL;
        end else begin
          st_next    = ST_OK;
          slot_next  = open_slot;
          wr_en      = 1'b1;
          set_bit    = 1'b1;
          count_next = live_count + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (match_found) begin
          st_next   = ST_OK;
          slot_next = match_slot;
          clr_bit   = 1'b1;
          if (live_count != '0) count_next = live_count - 1'b1;
        end
      end
      REQ_FIND: begin
        if (match_found) begin
          st_next   = ST_OK;
          slot_next = match_slot;
          id_next   = match_id;
        end
      end
      default: ;
    endcase
  end

  // memories: one write (commit) or one read (scan) per cycle
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      name_mem[open_slot] <= key;
      id_mem[open_slot]   <= id_q;
    end
    if (cmd.issue) begin
      rd_name <= name_mem[scan_addr];
      rd_id   <= id_mem[scan_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      live_count  <= '0;
      cmp_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      cmp_vld <= cmd.issue;
      if (cmd.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (cmp_vld) begin
        if (hit) match_found <= 1'b1;
        if (!cmp_bit) free_found <= 1'b1;
      end
      if (cmd.commit) begin
        live_count <= count_next;
        if (set_bit) valid_bits[open_slot] <= 1'b1;
        if (clr_bit) valid_bits[match_slot] <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= canon_name(in_name);
      req_q    <= in_req_type;
      id_q     <= in_entry_id;
      too_long <= (in_name[NAME_W-1 -: 8] != 8'h00);
    end
    if (cmd.issue) begin
      cmp_addr <= scan_addr;
      cmp_bit  <= valid_bits[scan_addr];
    end
    if (!cmd.load && cmp_vld) begin
      if (hit && !match_found) begin
        match_slot <= cmp_addr;
        match_id   <= rd_id;
      end
      if (!cmp_bit && !free_found) open_slot <= cmp_addr;
    end
    if (cmd.commit) begin
      status      <= st_next;
      slot_index  <= OUT_SLOT_W'(slot_next);
      found_id    <= id_next;
      entry_count <= OUT_COUNT_W'(count_next);
    end
  end

endmodule

>>> rtl/named_slot_table_core.sv
// Top level of the named slot table: controller plus datapath.
// Depends on nst_pkg, nst_if, nst_ctrl and nst_datapath.
`timescale 1ns / 1ps

// Named slot table: SLOTS entries, each a 32-byte name (zero-terminated,
// byte 0 in the low bits of name_word0) plus a 32-bit id. A request adds,
// removes or finds an entry by name and always returns exactly one response
// carrying a status, the slot touched, the found id and the live entry count
// after the request. Requests are handled one at a time: req.ready is high
// only while the block is idle. Each request walks every slot through the
// single read port of the name/id memory, one slot per cycle, then drains
// while the last compare retires and then commits. The block is idle again
// the cycle the response appears. Add, duplicate and free slot checks share
// that one walk; the lowest free slot and the first matching valid slot are
// both captured. The response sits in an output register, so the block
// returns to idle and takes the next request while an earlier response is
// still waiting on rsp.ready; the commit of the next request waits for that
// register to drain. Valid bits are cleared by reset; name and id memories
// are never cleared and their contents are only used behind a set valid bit.

module named_slot_table_core
  import nst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  nst_req_if.sink   req,
  nst_rsp_if.source rsp
);

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_W = $clog2(SLOTS + 1);

  nst_cmd_t          cmd;
  nst_stat_t         stat;
  logic [SLOT_W-1:0] scan_addr;

  // Sequencer: owns the handshakes and the scan address.
  nst_ctrl #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat),
    .scan_addr (scan_addr)
  );

  // Storage, compare and result register.
  nst_datapath #(
    .SLOTS   (SLOTS),
    .SLOT_W  (SLOT_W),
    .COUNT_W (COUNT_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .scan_addr   (scan_addr),
    .in_req_type (req.req_type),
    .in_name     ({req.name_word3, req.name_word2, req.name_word1, req.name_word0}),
    .in_entry_id (req.entry_id),
    .status      (rsp.status),
    .slot_index  (rsp.slot_index),
    .found_id    (rsp.found_id),
    .entry_count (rsp.entry_count)
  );

endmodule

>>> rtl/nst_checker.sv
// Port-level checks for named_slot_table_core, attached by bind.
// Depends on nst_pkg and named_slot_table_core_macros.svh.
`timescale 1ns / 1ps
`include "named_slot_table_core_macros.svh"

module nst_checker
  import nst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [OUT_SLOT_W-1:0]  slot_index,
  input logic [ID_W-1:0]        found_id,
  input logic [OUT_COUNT_W-1:0] entry_count
);

  // stalled response keeps its payload
  `NST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(slot_index) && $stable(found_id) && $stable(entry_count), "response changed while stalled")

  // one request in flight: ready drops right after an accept
  `NST_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request accepted while busy")

  // failed requests report zero slot and id
  `NST_ASSERT_NOW(a_fail_zero, rsp_valid && (status != ST_OK), (slot_index == '0) && (found_id == '0), "failure with nonzero slot or id")

  // count never exceeds the table size
  `NST_ASSERT_NOW(a_count_max, rsp_valid, (SLOTS > 127) || (entry_count <= SLOTS), "entry count above table size")

endmodule

bind named_slot_table_core nst_checker #(.SLOTS(SLOTS)) u_nst_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .slot_index  (rsp.slot_index),
  .found_id    (rsp.found_id),
  .entry_count (rsp.entry_count)
);

>>> bench/testbench.sv
// Self-checking bench for named_slot_table_core: add, remove and find requests
// are driven over the request channel and every response is checked in order.
// Depends on nst_pkg, nst_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import nst_pkg::*;

  localparam int TABLE_SLOTS    = SLOTS_DEF;
  localparam int POOL_SIZE      = 96;      // more names than slots, so adds can run full
  localparam int PHASE_ITEMS    = 445;
  localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
  localparam int TAIL_CYCLES    = 2 * (TABLE_SLOTS + 4);
  localparam int WATCHDOG_LIMIT = 6000;

  // The fourth request code is unused by the block; it must answer not found.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_ANY } traffic_mix_t;

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [NAME_W-1:0] name;   // word 0 in bits 63:0, byte 31 on top
    logic [ID_W-1:0]   id;
  } slot_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [OUT_SLOT_W-1:0]  slot;
    logic [ID_W-1:0]        id;
    logic [OUT_COUNT_W-1:0] count;
  } slot_result_t;

  // Shadow copy of the slot table plus the responses it still owes.
  class slot_ledger;
    bit                live[TABLE_SLOTS];
    logic [NAME_W-1:0] names[TABLE_SLOTS];
    logic [ID_W-1:0]   ids[TABLE_SLOTS];
    int unsigned       live_entries;
    slot_result_t      owed[$];
    int unsigned       errors;

    function new();
      foreach (live[s]) live[s] = 1'b0;
      live_entries = 0;
      errors = 0;
    endfunction

    // Everything after the first zero byte reads as zero.
    function logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] key;
      bit                ended;
      key   = '0;
      ended = 1'b0;
      for (int b = 0; b < NAME_BYTES; b++) begin
        if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
        if (!ended) key[8*b +: 8] = raw[8*b +: 8];
      end
      return key;
    endfunction

    function int lookup(logic [NAME_W-1:0] key);
      for (int s = 0; s < TABLE_SLOTS; s++)
        if (live[s] && names[s] == key) return s;
      return -1;
    endfunction

    function void note_request(slot_request_t r);
      logic [NAME_W-1:0] key;
      slot_result_t      res;
      int                hit;
      int                open_slot;
      bit                dup;
      key        = trim_name(r.name);
      res.status = ST_MISSING;
      res.slot   = '0;
      res.id     = '0;
      open_slot  = -1;
      dup        = 1'b0;
      case (r.op)
        REQ_ADD: begin
          // length is judged on the raw byte 31, before trimming
          if (r.name[NAME_W-1 -: 8] != 8'h00) begin
            res.status = ST_LONG;
          end else begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
              if (live[s]) begin
                if (names[s] == key) dup = 1'b1;
              end else if (open_slot < 0) begin
                open_slot = s;
              end
            end
            if (dup) begin
              res.status = ST_DUP;
            end else if (open_slot < 0) begin
              res.status = ST_FULL;
            end else begin
              live[open_slot]  = 1'b1;
              names[open_slot] = key;
              ids[open_slot]   = r.id;
              live_entries++;
              res.status = ST_OK;
              res.slot   = OUT_SLOT_W'(open_slot);
            end
          end
        end
        REQ_REMOVE: begin
          hit = lookup(key);
          if (hit >= 0) begin
            live[hit] = 1'b0;
            if (live_entries > 0) live_entries--;
            res.status = ST_OK;
            res.slot   = OUT_SLOT_W'(hit);
          end
        end
        REQ_FIND: begin
          hit = lookup(key);
          if (hit >= 0) begin
            res.status = ST_OK;
            res.slot   = OUT_SLOT_W'(hit);
            res.id     = ids[hit];
          end
        end
        default: ;
      endcase
      res.count = OUT_COUNT_W'(live_entries);
      owed.push_back(res);
    endfunction

    function void match_field(string what, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_response(slot_result_t got);
      slot_result_t want;
      if (owed.size() == 0) begin
        $display("%0t ns: response with nothing owed, actual %0h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      match_field("status", ID_W'(want.status), ID_W'(got.status));
      match_field("slot_index", ID_W'(want.slot), ID_W'(got.slot));
      match_field("found_id", want.id, got.id);
      match_field("entry_count", ID_W'(want.count), ID_W'(got.count));
    endfunction
  endclass

  logic clk;
  logic rst;

  nst_req_if req_ch ();
  nst_rsp_if rsp_ch ();

  named_slot_table_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_ledger ledger = new();

  // Idle rates in percent, per phase; receiver hold-off trigger.
  int send_idle_pct  = 6;
  int recv_idle_pct  = 70;
  int hold_req_count = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int walk_pos       = 0;

  logic [NAME_W-1:0] name_pool[POOL_SIZE];
  slot_result_t      observed;

  assign observed = {rsp_ch.status, rsp_ch.slot_index, rsp_ch.found_id, rsp_ch.entry_count};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random ready, or a long hold-off when the stimulus asks for one.
  // The hold lets the output register fill so the core stops taking requests.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_seen != hold_req_count) begin
      hold_seen    <= hold_req_count;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Response check plus a count of cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) ledger.check_response(observed);
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Scatter junk after the terminator; now and then byte 31 as well.
  function automatic logic [NAME_W-1:0] roughen(logic [NAME_W-1:0] key);
    logic [NAME_W-1:0] raw;
    int                term;
    raw  = key;
    term = 0;
    while (term < NAME_BYTES - 1 && key[8*term +: 8] != 8'h00) term++;
    for (int b = term + 1; b < NAME_BYTES - 1; b++) raw[8*b +: 8] = 8'($urandom());
    if ($urandom_range(0, 3) == 0) raw[NAME_W-1 -: 8] = 8'($urandom());
    return raw;
  endfunction

  // Fill walks the pool with adds so the table runs full; drain walks it
  // with removes; the mixed stream picks names at random.
  function automatic slot_request_t random_request(traffic_mix_t mix);
    slot_request_t r;
    int            roll;
    roll = $urandom_range(0, 99);
    r.id = $urandom();
    case (mix)
      MIX_FILL: begin
        r.op = (roll < 85) ? REQ_ADD : REQ_FIND;
        if (r.op == REQ_ADD) begin
          r.name = name_pool[walk_pos % POOL_SIZE];
          walk_pos++;
        end else begin
          r.name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
      end
      MIX_DRAIN: begin
        r.op = (roll < 70) ? REQ_REMOVE : REQ_FIND;
        r.name = name_pool[walk_pos % POOL_SIZE];
        if (r.op == REQ_REMOVE) walk_pos++;
      end
      default: begin
        r.op = (roll < 34) ? REQ_ADD : (roll < 67) ? REQ_REMOVE : REQ_FIND;
        r.name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 5)
      r.name = {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    else if (roll < 9)
      r.name[NAME_W-1 -: 8] = 8'($urandom_range(1, 255));
    else if (roll < 12)
      r.op = REQ_UNUSED;
    else if (roll < 32)
      r.name = roughen(r.name);
    return r;
  endfunction

  // Offer one request, with an optional idle gap first; valid stays high
  // after the handshake so back-to-back requests never drop it.
  task automatic send_request(input slot_request_t r);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.op;
    req_ch.name_word0 <= r.name[63:0];
    req_ch.name_word1 <= r.name[127:64];
    req_ch.name_word2 <= r.name[191:128];
    req_ch.name_word3 <= r.name[255:192];
    req_ch.entry_id   <= r.id;
    do @(posedge clk); while (!req_ch.ready);
    ledger.note_request(r);
  endtask

  // Stop offering until every owed response is back.
  task automatic drain_all();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.owed.size() != 0);
  endtask

  function automatic slot_request_t mk(logic [REQ_W-1:0] op, logic [NAME_W-1:0] name,
                                       logic [ID_W-1:0] id);
    slot_request_t r;
    r.op   = op;
    r.name = name;
    r.id   = id;
    return r;
  endfunction

  initial begin
    slot_request_t     directed[$];
    logic [NAME_W-1:0] ones;
    logic [NAME_W-1:0] all_ones;
    logic [NAME_W-1:0] a_junk;
    logic [NAME_W-1:0] empty_long;
    logic [NAME_W-1:0] cand;
    traffic_mix_t      mix;
    int                sent;
    int                seg_len;
    int                len;
    bit                clash;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_ADD;
    req_ch.name_word0 <= '0;
    req_ch.name_word1 <= '0;
    req_ch.name_word2 <= '0;
    req_ch.name_word3 <= '0;
    req_ch.entry_id   <= '0;

    // Pool of distinct, already trimmed names: mostly short, some near 31 bytes.
    for (int p = 0; p < POOL_SIZE; p++) begin
      do begin
        cand = '0;
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 12);
        for (int b = 0; b < len; b++) cand[8*b +: 8] = 8'($urandom_range(1, 255));
        clash = 1'b0;
        for (int q = 0; q < p; q++) if (name_pool[q] == cand) clash = 1'b1;
      end while (clash);
      name_pool[p] = cand;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 31-byte name of all ones, over-long names, junk after the
    // terminator, the empty name, the unused code, count floor, lowest free.
    ones       = {8'h00, {31{8'hFF}}};
    all_ones   = {32{8'hFF}};
    a_junk     = {8'h00, {29{8'hA5}}, 8'h00, 8'h41};
    empty_long = {8'h7E, {30{8'h3C}}, 8'h00};
    directed.push_back(mk(REQ_FIND,   '0,         32'h0));
    directed.push_back(mk(REQ_REMOVE, '0,         32'h0));
    directed.push_back(mk(REQ_ADD,    ones,       32'hFFFF_FFFF));
    directed.push_back(mk(REQ_ADD,    ones,       32'h0));
    directed.push_back(mk(REQ_ADD,    all_ones,   32'h1));
    directed.push_back(mk(REQ_FIND,   all_ones,   32'h0));
    directed.push_back(mk(REQ_REMOVE, all_ones,   32'h0));
    directed.push_back(mk(REQ_ADD,    a_junk,     32'h0));
    directed.push_back(mk(REQ_FIND,   256'h41,    32'h0));
    directed.push_back(mk(REQ_ADD,    256'h41,    32'h5));
    directed.push_back(mk(REQ_ADD,    empty_long, 32'h9));
    directed.push_back(mk(REQ_ADD,    '0,         32'h1234_5678));
    directed.push_back(mk(REQ_FIND,   empty_long, 32'h0));
    directed.push_back(mk(REQ_UNUSED, ones,       32'hDEAD_BEEF));
    directed.push_back(mk(REQ_FIND,   ones,       32'h0));
    directed.push_back(mk(REQ_REMOVE, ones,       32'h0));
    directed.push_back(mk(REQ_REMOVE, ones,       32'h0));
    directed.push_back(mk(REQ_ADD,    256'h80,    32'hA5A5_A5A5));
    directed.push_back(mk(REQ_REMOVE, a_junk,     32'h0));
    directed.push_back(mk(REQ_REMOVE, '0,         32'h0));
    directed.push_back(mk(REQ_REMOVE, 256'h80,    32'h0));
    directed.push_back(mk(REQ_REMOVE, 256'h80,    32'h0));
    foreach (directed[i]) send_request(directed[i]);
    drain_all();

    // Random traffic in three idle profiles: slow receiver, slow sender, none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 6;  recv_idle_pct = 70; end
        1:       begin send_idle_pct = 70; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      // long receiver stall while requests keep coming
      if (phase < 2) hold_req_count <= hold_req_count + 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mix     = traffic_mix_t'($urandom_range(0, 2));
        seg_len = (mix == MIX_ANY) ? $urandom_range(30, 60) : 90;
        for (int i = 0; i < seg_len && sent < PHASE_ITEMS; i++) begin
          send_request(random_request(mix));
          sent++;
        end
        // at least one mid-phase pause with the pipe fully drained
        if (phase == 2 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 90)
          drain_all();
      end
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.owed.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
